@@ rtl/rc_channel_camera_action_mapper_top_defines.svh @@
// Assertion macros for the camera action mapper.
// Included by the top level only; no other dependencies.
`ifndef RC_CHANNEL_CAMERA_ACTION_MAPPER_TOP_DEFINES_SVH
`define RC_CHANNEL_CAMERA_ACTION_MAPPER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RCCAM_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rccam assertion failed");

// next-cycle implication, disabled in reset
`define RCCAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rccam assertion failed");

`endif

@@ rtl/rccam_pkg.sv @@
// Shared types and constants for the camera action mapper.
// No dependencies.
package rccam_pkg;

   localparam int NUM_FUNCS    = 5;
   localparam int AUX_CHANNELS = 6;
   localparam int AUX_W        = 12;
   localparam int MAP_W        = 27;
   localparam int DELAY_W      = 16;
   localparam int TIME_W       = 32;
   localparam int NUM_SLOTS    = 6;

   // register indexes on the csr port
   localparam logic [3:0] CSR_FUNC0      = 4'd0;
   localparam logic [3:0] CSR_FUNC1      = 4'd1;
   localparam logic [3:0] CSR_FUNC2      = 4'd2;
   localparam logic [3:0] CSR_FUNC3      = 4'd3;
   localparam logic [3:0] CSR_FUNC4      = 4'd4;
   localparam logic [3:0] CSR_MODE_FLAGS = 4'd5;
   localparam logic [3:0] CSR_START_DLY  = 4'd6;
   localparam logic [3:0] CSR_STOP_DLY   = 4'd7;

   // mode flag bits
   localparam int MF_SHUTTER_2POS = 0;
   localparam int MF_MODE_2POS    = 1;
   localparam int MF_REC_ON_ARM   = 2;

   // function indexes
   localparam int FN_SHUTTER = 0;
   localparam int FN_MODE    = 1;

   typedef enum logic [2:0] {
      ACT_START           = 3'd0,
      ACT_STOP            = 3'd1,
      ACT_PHOTO           = 3'd2,
      ACT_MODE_PHOTO      = 3'd3,
      ACT_MODE_VIDEO      = 3'd4,
      ACT_PRESET_VIDEO    = 3'd5,
      ACT_PRESET_PHOTO    = 3'd6,
      ACT_PRESET_TIMELAPS = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      PEND_NONE  = 2'd0,
      PEND_START = 2'd1,
      PEND_STOP  = 2'd2
   } pend_type;

   typedef struct packed {
      logic [NUM_FUNCS-1:0][MAP_W-1:0] func_map;
      logic [2:0]                      mode_flags;
      logic [DELAY_W-1:0]              start_delay;
      logic [DELAY_W-1:0]              stop_delay;
   } cfg_type;

   typedef struct packed {
      logic [AUX_CHANNELS-1:0][AUX_W-1:0] aux;
      logic                                rc_valid;
      logic                                armed;
      logic                                cam_photo;
      logic                                cam_recording;
      logic [TIME_W-1:0]                   now_ms;
   } frame_type;

   typedef struct packed {
      pend_type              pending_kind;
      logic [TIME_W-1:0]     pending_deadline;
      logic                  edge_primed;
      logic                  arm_primed;
      logic                  last_armed;
      logic [NUM_FUNCS-1:0]  last_active;
   } state_type;

   // slot 0: delayed command firing, slots 1..5: functions 0..4
   // (slot 1 also carries the record-on-arm command)
   typedef struct packed {
      logic [NUM_SLOTS-1:0]        mask;
      logic [NUM_SLOTS-1:0][2:0]   act;
   } result_type;

endpackage

@@ rtl/rccam_eval.sv @@
// Frame evaluation: pending fire, record-on-arm, window tests and edge actions.
// Pure combinational; depends on rccam_pkg.
module rccam_eval (
   input  rccam_pkg::cfg_type    cfg,
   input  rccam_pkg::state_type  state,
   input  rccam_pkg::frame_type  frame,
   output rccam_pkg::result_type result,
   output rccam_pkg::state_type  state_in
);

   logic [rccam_pkg::TIME_W-1:0]    since_deadline;
   logic [rccam_pkg::NUM_FUNCS-1:0] active;
   logic [rccam_pkg::NUM_FUNCS-1:0] changed;
   logic                            sched_req;
   logic                            sched_start;
   logic [rccam_pkg::DELAY_W-1:0]   sched_delay;

   assign since_deadline = frame.now_ms - state.pending_deadline;

   // window test per function
   always_comb begin
      for (int i = 0; i < rccam_pkg::NUM_FUNCS; i++) begin
         logic [2:0]                  sel;
         logic [2:0]                  sel_idx;
         logic [rccam_pkg::AUX_W-1:0] lo;
         logic [rccam_pkg::AUX_W-1:0] hi;
         logic [rccam_pkg::AUX_W-1:0] v;
         sel     = cfg.func_map[i][2:0];
         lo      = cfg.func_map[i][14:3];
         hi      = cfg.func_map[i][26:15];
         sel_idx = sel - 3'd1;
         v       = '0;
         if (sel != 3'd0 && 32'(sel) <= rccam_pkg::AUX_CHANNELS) begin
            v = frame.aux[sel_idx];
         end
         active[i] = (sel != 3'd0) && (32'(sel) <= rccam_pkg::AUX_CHANNELS) &&
                     (v >= lo) && (v <= hi);
      end
   end

   assign changed = active ^ state.last_active;

   always_comb begin
      result      = '0;
      state_in    = state;
      sched_req   = 1'b0;
      sched_start = 1'b0;

      if (state.pending_kind != rccam_pkg::PEND_NONE && !since_deadline[31]) begin
         result.mask[0] = 1'b1;
         result.act[0]  = (state.pending_kind == rccam_pkg::PEND_START) ?
                          rccam_pkg::ACT_START : rccam_pkg::ACT_STOP;
         state_in.pending_kind = rccam_pkg::PEND_NONE;
      end

      if (cfg.mode_flags[rccam_pkg::MF_REC_ON_ARM]) begin
         if (!state.arm_primed) begin
            state_in.last_armed = frame.armed;
            state_in.arm_primed = 1'b1;
         end else if (frame.armed != state.last_armed) begin
            state_in.last_armed = frame.armed;
            sched_req   = 1'b1;
            sched_start = frame.armed;
         end
      end else if (frame.rc_valid) begin
         state_in.last_active = active;
         if (!state.edge_primed) begin
            state_in.edge_primed = 1'b1;
         end else begin
            // shutter
            if (changed[rccam_pkg::FN_SHUTTER]) begin
               if (frame.cam_photo) begin
                  if (active[rccam_pkg::FN_SHUTTER]) begin
                     result.mask[1] = 1'b1;
                     result.act[1]  = rccam_pkg::ACT_PHOTO;
                  end
               end else if (cfg.mode_flags[rccam_pkg::MF_SHUTTER_2POS]) begin
                  sched_req   = 1'b1;
                  sched_start = active[rccam_pkg::FN_SHUTTER];
               end else if (active[rccam_pkg::FN_SHUTTER]) begin
                  sched_req   = 1'b1;
                  sched_start = !frame.cam_recording;
               end
            end
            // camera mode
            if (changed[rccam_pkg::FN_MODE]) begin
               if (cfg.mode_flags[rccam_pkg::MF_MODE_2POS]) begin
                  result.mask[2] = 1'b1;
                  result.act[2]  = active[rccam_pkg::FN_MODE] ?
                                   rccam_pkg::ACT_MODE_PHOTO : rccam_pkg::ACT_MODE_VIDEO;
               end else if (active[rccam_pkg::FN_MODE]) begin
                  result.mask[2] = 1'b1;
                  result.act[2]  = frame.cam_photo ?
                                   rccam_pkg::ACT_MODE_VIDEO : rccam_pkg::ACT_MODE_PHOTO;
               end
            end
            // presets, rising edge only
            for (int i = 2; i < rccam_pkg::NUM_FUNCS; i++) begin
               if (changed[i] && active[i]) begin
                  result.mask[i+1] = 1'b1;
                  result.act[i+1]  = 3'(32'(rccam_pkg::ACT_PRESET_VIDEO) + i - 2);
               end
            end
         end
      end

      // a zero delay acts at once, otherwise it replaces the held command
      sched_delay = sched_start ? cfg.start_delay : cfg.stop_delay;
      if (sched_req) begin
         if (sched_delay == '0) begin
            result.mask[1] = 1'b1;
            result.act[1]  = sched_start ? rccam_pkg::ACT_START : rccam_pkg::ACT_STOP;
         end else begin
            state_in.pending_kind     = sched_start ? rccam_pkg::PEND_START :
                                                      rccam_pkg::PEND_STOP;
            state_in.pending_deadline = frame.now_ms +
                                        {{(rccam_pkg::TIME_W-rccam_pkg::DELAY_W){1'b0}},
                                         sched_delay};
         end
      end
   end

endmodule

@@ rtl/rccam_drain.sv @@
// Result buffer: holds one frame's action slots and sends them one word a cycle while rsp_stall is low.
// Depends on rccam_pkg.
module rccam_drain (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rccam_pkg::result_type result,
   output logic                  ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_action,
   output logic                  rsp_last
);

   logic [rccam_pkg::NUM_SLOTS-1:0]      mask_ff;
   logic [rccam_pkg::NUM_SLOTS-1:0]      mask_in;
   logic [rccam_pkg::NUM_SLOTS-1:0][2:0] act_ff;
   logic [rccam_pkg::NUM_SLOTS-1:0]      low_bit;
   logic [rccam_pkg::NUM_SLOTS-1:0]      rest;
   logic                                 taken;

   assign low_bit   = mask_ff & (~mask_ff + 1'b1);
   assign rest      = mask_ff & ~low_bit;
   assign rsp_valid = |mask_ff;
   assign rsp_last  = (rest == '0);
   assign taken     = rsp_valid && !rsp_stall;
   assign ready     = !rsp_valid || (taken && rsp_last);

   always_comb begin
      rsp_action = act_ff[0];
      for (int i = rccam_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            rsp_action = act_ff[i];
         end
      end
   end

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = result.mask;
      end else if (taken) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      if (load) begin
         act_ff <= result.act;
      end
   end

endmodule

@@ rtl/rc_channel_camera_action_mapper_top.sv @@
// Camera action mapper top level: frame register, control registers, state, and
// the evaluation and result-buffer stages. Depends on rccam_pkg, rccam_eval,
// rccam_drain and the assertion macro header.
//
// A frame is registered on acceptance and evaluated once the result buffer is
// free; its 0 to 6 action words then leave one per cycle while rsp_stall is low,
// in order (pending fire, then functions 0 to 4), the final one flagged last.
// The frame passes the frame register and then the result buffer's mask register
// before its first word is presented. A frame's words hold the single result
// port while they drain; the next frame is taken while words still drain.
// Control registers are to be written only while the block is idle; the block
// itself does not enforce this. Any listed write cancels a held record command
// and re-primes edge detection.
`include "rc_channel_camera_action_mapper_top_defines.svh"

module rc_channel_camera_action_mapper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_aux_one,
   input  logic [11:0] req_aux_two,
   input  logic [11:0] req_aux_three,
   input  logic [11:0] req_aux_four,
   input  logic [11:0] req_aux_five,
   input  logic [11:0] req_aux_six,
   input  logic        req_rc_valid,
   input  logic        req_armed,
   input  logic        req_cam_photo,
   input  logic        req_cam_recording,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_action,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_index,
   input  logic [26:0] csr_wdata
);

   logic                  in_valid_ff;
   rccam_pkg::frame_type  frame_ff;
   rccam_pkg::state_type  state_ff;
   rccam_pkg::state_type  state_in;
   rccam_pkg::cfg_type    cfg_ff;
   rccam_pkg::result_type result;
   logic                  drain_ready;
   logic                  advance;
   logic                  req_take;
   logic                  csr_hit;

   assign advance   = in_valid_ff && drain_ready;
   assign req_stall = in_valid_ff && !drain_ready;
   assign req_take  = req_valid && !req_stall;
   assign csr_hit   = csr_wr_en && (csr_index <= rccam_pkg::CSR_STOP_DLY);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         frame_ff.aux           <= {req_aux_six, req_aux_five, req_aux_four,
                                    req_aux_three, req_aux_two, req_aux_one};
         frame_ff.rc_valid      <= req_rc_valid;
         frame_ff.armed         <= req_armed;
         frame_ff.cam_photo     <= req_cam_photo;
         frame_ff.cam_recording <= req_cam_recording;
         frame_ff.now_ms        <= req_now_ms;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rccam_pkg::CSR_FUNC0:      cfg_ff.func_map[0]  <= csr_wdata;
            rccam_pkg::CSR_FUNC1:      cfg_ff.func_map[1]  <= csr_wdata;
            rccam_pkg::CSR_FUNC2:      cfg_ff.func_map[2]  <= csr_wdata;
            rccam_pkg::CSR_FUNC3:      cfg_ff.func_map[3]  <= csr_wdata;
            rccam_pkg::CSR_FUNC4:      cfg_ff.func_map[4]  <= csr_wdata;
            rccam_pkg::CSR_MODE_FLAGS: cfg_ff.mode_flags   <= csr_wdata[2:0];
            rccam_pkg::CSR_START_DLY:  cfg_ff.start_delay  <= csr_wdata[15:0];
            rccam_pkg::CSR_STOP_DLY:   cfg_ff.stop_delay   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{pending_kind: rccam_pkg::PEND_NONE, default: '0};
      end else if (csr_hit) begin
         state_ff.pending_kind <= rccam_pkg::PEND_NONE;
         state_ff.edge_primed  <= 1'b0;
         state_ff.arm_primed   <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   rccam_eval u_eval (
      .cfg      (cfg_ff),
      .state    (state_ff),
      .frame    (frame_ff),
      .result   (result),
      .state_in (state_in)
   );

   rccam_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .ready      (drain_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_action (rsp_action),
      .rsp_last   (rsp_last)
   );

   // a frame never leaves its register while more than one word is still queued
   `RCCAM_ASSERT(a_no_overrun, clock, reset, rsp_valid && !rsp_last, !advance)
   // nothing fires unless a command is held
   `RCCAM_ASSERT(a_fire_needs_pending, clock, reset,
                 advance && (state_ff.pending_kind == rccam_pkg::PEND_NONE), !result.mask[0])
   // record-on-arm frames use only the fire and arm slots
   `RCCAM_ASSERT(a_arm_mode_slots, clock, reset,
                 advance && cfg_ff.mode_flags[rccam_pkg::MF_REC_ON_ARM], result.mask[5:2] == 4'd0)
   // a loaded frame with words shows them in the next cycle
   `RCCAM_ASSERT_NEXT(a_load_shows, clock, reset, advance && (result.mask != 6'd0), rsp_valid)

endmodule

@@ sim/rc_channel_camera_action_mapper_top_test.sv @@
// Self-checking bench for the camera action mapper: drives update frames and
// register writes, predicts the action words and checks them in order.
// Depends on rccam_pkg and rc_channel_camera_action_mapper_top.
module rc_channel_camera_action_mapper_top_test;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 38;

   // keeps its own copy of the registers and state, and the words still owed
   class camera_action_board;
      logic [rccam_pkg::MAP_W-1:0]     win_map[rccam_pkg::NUM_FUNCS];
      logic [2:0]                      flags;
      logic [rccam_pkg::DELAY_W-1:0]   start_ms;
      logic [rccam_pkg::DELAY_W-1:0]   stop_ms;
      rccam_pkg::pend_type             held_cmd;
      logic [rccam_pkg::TIME_W-1:0]    held_due;
      bit                              func_primed;
      bit                              arm_primed;
      bit                              prev_armed;
      logic [rccam_pkg::NUM_FUNCS-1:0] prev_hits;
      rccam_pkg::action_type           frame_acts[$];
      rccam_pkg::action_type           awaited_actions[$];
      bit                              awaited_last[$];
      int                              errors;

      function new();
         foreach (win_map[i]) win_map[i] = '0;
         flags = '0;
         start_ms = '0;
         stop_ms = '0;
         held_cmd = rccam_pkg::PEND_NONE;
         held_due = '0;
         func_primed = 0;
         arm_primed = 0;
         prev_armed = 0;
         prev_hits = '0;
         errors = 0;
      endfunction

      function bit empty();
         return awaited_actions.size() == 0;
      endfunction

      function void take_config(logic [3:0] idx, logic [rccam_pkg::MAP_W-1:0] val);
         unique case (idx)
            rccam_pkg::CSR_FUNC0, rccam_pkg::CSR_FUNC1, rccam_pkg::CSR_FUNC2,
            rccam_pkg::CSR_FUNC3, rccam_pkg::CSR_FUNC4: win_map[idx] = val;
            rccam_pkg::CSR_MODE_FLAGS: flags = val[2:0];
            rccam_pkg::CSR_START_DLY: start_ms = val[rccam_pkg::DELAY_W-1:0];
            rccam_pkg::CSR_STOP_DLY: stop_ms = val[rccam_pkg::DELAY_W-1:0];
            default: return;
         endcase
         held_cmd = rccam_pkg::PEND_NONE;
         func_primed = 0;
         arm_primed = 0;
      endfunction

      function void schedule_record(bit start, logic [rccam_pkg::TIME_W-1:0] now);
         logic [rccam_pkg::DELAY_W-1:0] d;
         d = start ? start_ms : stop_ms;
         if (d == 0) begin
            if (start) frame_acts.push_back(rccam_pkg::ACT_START);
            else frame_acts.push_back(rccam_pkg::ACT_STOP);
         end else begin
            if (start) held_cmd = rccam_pkg::PEND_START;
            else held_cmd = rccam_pkg::PEND_STOP;
            held_due = now + d;
         end
      endfunction

      function void take_frame(rccam_pkg::frame_type f);
         logic [rccam_pkg::TIME_W-1:0]    lag;
         logic [rccam_pkg::NUM_FUNCS-1:0] hits;
         logic [rccam_pkg::MAP_W-1:0]     m;
         logic [2:0]                      sel;
         logic [rccam_pkg::AUX_W-1:0]     v;
         bit                              rising;
         frame_acts.delete();
         if (held_cmd != rccam_pkg::PEND_NONE) begin
            // deadline reached when the wrapped difference is not negative
            lag = f.now_ms - held_due;
            if (!lag[rccam_pkg::TIME_W-1]) begin
               if (held_cmd == rccam_pkg::PEND_START) frame_acts.push_back(rccam_pkg::ACT_START);
               else frame_acts.push_back(rccam_pkg::ACT_STOP);
               held_cmd = rccam_pkg::PEND_NONE;
            end
         end
         if (flags[rccam_pkg::MF_REC_ON_ARM]) begin
            if (!arm_primed) begin
               prev_armed = f.armed;
               arm_primed = 1;
            end else if (f.armed != prev_armed) begin
               prev_armed = f.armed;
               schedule_record(f.armed, f.now_ms);
            end
         end else if (f.rc_valid) begin
            hits = '0;
            for (int i = 0; i < rccam_pkg::NUM_FUNCS; i++) begin
               m = win_map[i];
               sel = m[2:0];
               if (sel != 0 && sel <= rccam_pkg::AUX_CHANNELS) begin
                  v = f.aux[sel - 1];
                  if (v >= m[14:3] && v <= m[26:15]) hits[i] = 1'b1;
               end
            end
            if (!func_primed) begin
               prev_hits = hits;
               func_primed = 1;
            end else begin
               for (int i = 0; i < rccam_pkg::NUM_FUNCS; i++) begin
                  if (hits[i] != prev_hits[i]) begin
                     rising = hits[i];
                     if (i == rccam_pkg::FN_SHUTTER) begin
                        if (f.cam_photo) begin
                           if (rising) frame_acts.push_back(rccam_pkg::ACT_PHOTO);
                        end else if (flags[rccam_pkg::MF_SHUTTER_2POS]) begin
                           schedule_record(rising, f.now_ms);
                        end else if (rising) begin
                           schedule_record(!f.cam_recording, f.now_ms);
                        end
                     end else if (i == rccam_pkg::FN_MODE) begin
                        if (flags[rccam_pkg::MF_MODE_2POS]) begin
                           if (rising) frame_acts.push_back(rccam_pkg::ACT_MODE_PHOTO);
                           else frame_acts.push_back(rccam_pkg::ACT_MODE_VIDEO);
                        end else if (rising) begin
                           if (f.cam_photo) frame_acts.push_back(rccam_pkg::ACT_MODE_VIDEO);
                           else frame_acts.push_back(rccam_pkg::ACT_MODE_PHOTO);
                        end
                     end else if (rising) begin
                        // presets follow the mode function in order
                        frame_acts.push_back(rccam_pkg::action_type'(
                           rccam_pkg::ACT_PRESET_VIDEO + i - rccam_pkg::FN_MODE - 1));
                     end
                  end
               end
               prev_hits = hits;
            end
         end
         foreach (frame_acts[k]) begin
            awaited_actions.push_back(frame_acts[k]);
            awaited_last.push_back(k == frame_acts.size() - 1);
         end
      endfunction

      function void check_word(logic [2:0] act, logic last);
         rccam_pkg::action_type want;
         bit                    want_last;
         if (awaited_actions.size() == 0) begin
            $error("unexpected word: action %0d last %0d", act, last);
            errors++;
            return;
         end
         want = awaited_actions.pop_front();
         want_last = awaited_last.pop_front();
         if (act !== want) begin
            $error("action: expected %0d, actual %0d", want, act);
            errors++;
         end
         if (last !== want_last) begin
            $error("last: expected %0d, actual %0d", want_last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [11:0] req_aux_one;
   logic [11:0] req_aux_two;
   logic [11:0] req_aux_three;
   logic [11:0] req_aux_four;
   logic [11:0] req_aux_five;
   logic [11:0] req_aux_six;
   logic        req_rc_valid;
   logic        req_armed;
   logic        req_cam_photo;
   logic        req_cam_recording;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_action;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [3:0]  csr_index;
   logic [26:0] csr_wdata;

   camera_action_board           board;
   int                           items_sent;
   int                           quiet_cycles;
   logic [rccam_pkg::TIME_W-1:0] ms_clock;
   bit                           armed_now;

   rc_channel_camera_action_mapper_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // idle mix: sender light / receiver heavy, then swapped, then none
   function int sender_gap_pct();
      if (items_sent < 134) return 8;
      if (items_sent < 268) return 51;
      return 0;
   endfunction

   function int receiver_stall_pct();
      if (items_sent < 134) return 51;
      if (items_sent < 268) return 8;
      return 0;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_word(rsp_action, rsp_last);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("rc_channel_camera_action_mapper_top_test: errors");
         $finish;
      end
   end

   function logic [rccam_pkg::MAP_W-1:0] pack_map(int sel, int lo, int hi);
      return {hi[11:0], lo[11:0], sel[2:0]};
   endfunction

   function rccam_pkg::frame_type make_frame(int a1, int a2, int a3, int a4, int a5, int a6,
                                             bit valid, bit armed, bit photo, bit rec,
                                             logic [rccam_pkg::TIME_W-1:0] now);
      rccam_pkg::frame_type f;
      f.aux[0] = a1[11:0];
      f.aux[1] = a2[11:0];
      f.aux[2] = a3[11:0];
      f.aux[3] = a4[11:0];
      f.aux[4] = a5[11:0];
      f.aux[5] = a6[11:0];
      f.rc_valid = valid;
      f.armed = armed;
      f.cam_photo = photo;
      f.cam_recording = rec;
      f.now_ms = now;
      return f;
   endfunction

   // aimed at the window of a function reading this channel, so edges happen
   function logic [rccam_pkg::AUX_W-1:0] pick_aux(int ch);
      logic [rccam_pkg::MAP_W-1:0] m;
      int                          lo;
      int                          hi;
      int                          r;
      bit                          done;
      logic [rccam_pkg::AUX_W-1:0] v;
      v = 12'($urandom_range(0, 4095));
      r = $urandom_range(0, 99);
      done = 0;
      if (r < 10) begin
         v = (r < 5) ? 12'h000 : 12'hFFF;
      end else begin
         for (int i = 0; i < rccam_pkg::NUM_FUNCS; i++) begin
            m = board.win_map[i];
            if (!done && m[2:0] == ch + 1) begin
               done = 1;
               lo = m[14:3];
               hi = m[26:15];
               if (r < 60 && lo <= hi) v = 12'($urandom_range(lo, hi));
               else if (r < 85 && lo > 0) v = 12'($urandom_range(0, lo - 1));
               else if (r < 85 && hi < 4095) v = 12'($urandom_range(hi + 1, 4095));
            end
         end
      end
      return v;
   endfunction

   function rccam_pkg::frame_type random_frame();
      rccam_pkg::frame_type f;
      int                   r;
      for (int ch = 0; ch < rccam_pkg::AUX_CHANNELS; ch++) f.aux[ch] = pick_aux(ch);
      f.rc_valid = ($urandom_range(0, 99) < 88);
      if ($urandom_range(0, 3) == 0) armed_now = !armed_now;
      f.armed = armed_now;
      f.cam_photo = 1'($urandom_range(0, 1));
      f.cam_recording = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 90) ms_clock = ms_clock + $urandom_range(0, 25);
      else if (r < 97) ms_clock = ms_clock + $urandom_range(0, 70000);
      else ms_clock = $urandom;
      f.now_ms = ms_clock;
      return f;
   endfunction

   task automatic send_frame(input rccam_pkg::frame_type f);
      while ($urandom_range(0, 99) < sender_gap_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_aux_one <= f.aux[0];
      req_aux_two <= f.aux[1];
      req_aux_three <= f.aux[2];
      req_aux_four <= f.aux[3];
      req_aux_five <= f.aux[4];
      req_aux_six <= f.aux[5];
      req_rc_valid <= f.rc_valid;
      req_armed <= f.armed;
      req_cam_photo <= f.cam_photo;
      req_cam_recording <= f.cam_recording;
      req_now_ms <= f.now_ms;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_frame(f);
      items_sent++;
   endtask

   // hold off until every owed word is out and a frame with no words has settled
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (!board.empty()) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [rccam_pkg::MAP_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.take_config(idx, val);
   endtask

   task automatic load_config(input logic [rccam_pkg::MAP_W-1:0] f0, f1, f2, f3, f4,
                              input logic [rccam_pkg::MAP_W-1:0] mode, sdly, pdly);
      write_reg(rccam_pkg::CSR_FUNC0, f0);
      write_reg(rccam_pkg::CSR_FUNC1, f1);
      write_reg(rccam_pkg::CSR_FUNC2, f2);
      write_reg(rccam_pkg::CSR_FUNC3, f3);
      write_reg(rccam_pkg::CSR_FUNC4, f4);
      write_reg(rccam_pkg::CSR_MODE_FLAGS, mode);
      write_reg(rccam_pkg::CSR_START_DLY, sdly);
      write_reg(rccam_pkg::CSR_STOP_DLY, pdly);
      csr_wr_en <= 1'b0;
   endtask

   function logic [rccam_pkg::MAP_W-1:0] rand_window();
      int lo;
      int hi;
      lo = $urandom_range(0, 4095);
      if ($urandom_range(0, 99) < 80) hi = $urandom_range(lo, 4095);
      else hi = $urandom_range(0, 4095);
      return pack_map($urandom_range(0, 7), lo, hi);
   endfunction

   // upper bits carry junk that the block must drop
   function logic [rccam_pkg::MAP_W-1:0] rand_delay();
      logic [rccam_pkg::MAP_W-1:0] val;
      int                          r;
      val = 27'($urandom);
      r = $urandom_range(0, 9);
      if (r < 4) val[15:0] = '0;
      else if (r < 8) val[15:0] = 16'($urandom_range(1, 50));
      else if (r == 8) val[15:0] = 16'hFFFF;
      return val;
   endfunction

   task automatic random_config();
      logic [rccam_pkg::MAP_W-1:0] mode;
      mode = 27'($urandom);
      mode[rccam_pkg::MF_REC_ON_ARM] = ($urandom_range(0, 9) < 3);
      if ($urandom_range(0, 2) == 0)
         write_reg(4'(rccam_pkg::CSR_STOP_DLY + $urandom_range(1, 8)), 27'($urandom));
      load_config(rand_window(), rand_window(), rand_window(), rand_window(),
                  rand_window(), mode, rand_delay(), rand_delay());
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_aux_one = '0;
      req_aux_two = '0;
      req_aux_three = '0;
      req_aux_four = '0;
      req_aux_five = '0;
      req_aux_six = '0;
      req_rc_valid = 1'b0;
      req_armed = 1'b0;
      req_cam_photo = 1'b0;
      req_cam_recording = 1'b0;
      req_now_ms = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = rccam_pkg::CSR_FUNC0;
      csr_wdata = '0;
      items_sent = 0;
      quiet_cycles = 0;
      armed_now = 0;
      ms_clock = 32'hFFFF_F000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // two-position shutter and mode, edge windows at the channel extremes
      load_config(pack_map(1, 1000, 3000), pack_map(2, 2048, 4095), pack_map(3, 0, 0),
                  pack_map(6, 4095, 4095), pack_map(5, 3000, 1000), 27'd3, 27'd0, 27'd0);
      send_frame(make_frame(0, 0, 4095, 0, 0, 0, 1, 0, 0, 0, 32'd0));
      send_frame(make_frame(1000, 4095, 0, 0, 2000, 4095, 1, 0, 0, 0, 32'd1));
      send_frame(make_frame(3001, 2047, 1, 0, 4095, 4094, 1, 0, 0, 1, 32'd2));
      send_frame(make_frame(1500, 4095, 0, 4095, 0, 4095, 0, 0, 0, 0, 32'd3));
      send_frame(make_frame(3000, 4095, 1, 0, 0, 0, 1, 0, 1, 0, 32'd4));
      send_frame(make_frame(0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 32'd5));

      // toggle style with a held start
      quiesce();
      load_config(pack_map(1, 1000, 3000), pack_map(2, 2048, 4095), pack_map(3, 0, 0),
                  pack_map(6, 4095, 4095), pack_map(5, 3000, 1000), 27'd0, 27'd20, 27'd0);
      send_frame(make_frame(0, 0, 4095, 0, 0, 0, 1, 0, 0, 0, 32'd100));
      send_frame(make_frame(1500, 3000, 4095, 0, 0, 0, 1, 0, 0, 0, 32'd101));
      send_frame(make_frame(0, 0, 4095, 0, 0, 0, 1, 0, 0, 0, 32'd110));
      send_frame(make_frame(1500, 3000, 4095, 0, 0, 0, 1, 0, 0, 1, 32'd121));

      // record on arm across the time wrap, and a deadline half a range away
      quiesce();
      load_config(27'd0, 27'd0, 27'd0, 27'd0, 27'd0, 27'd4, 27'd65535, 27'd30);
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 32'hFFFF_FF00));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 32'hFFFF_FF10));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 32'h0000_0005));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 32'h8001_0000));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 32'h0001_0004));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0004));

      // all ones everywhere; writes past the register list must change nothing
      quiesce();
      write_reg(4'(rccam_pkg::CSR_STOP_DLY + 1), 27'h7FF_FFFF);
      write_reg(4'(rccam_pkg::CSR_STOP_DLY + 8), 27'd0);
      load_config(27'h7FF_FFFF, 27'h7FF_FFFF, 27'h7FF_FFFF, 27'h7FF_FFFF, 27'h7FF_FFFF,
                  27'h7FF_FFFF, 27'h7FF_FFFF, 27'h7FF_FFFF);
      send_frame(make_frame(4095, 4095, 4095, 4095, 4095, 4095, 1, 0, 1, 1, 32'd1000));
      send_frame(make_frame(4095, 4095, 4095, 4095, 4095, 4095, 1, 1, 1, 1, 32'd1001));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 32'd66535));
      send_frame(make_frame(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 32'd66536));

      // all zero: every function off
      quiesce();
      load_config(27'd0, 27'd0, 27'd0, 27'd0, 27'd0, 27'd0, 27'd0, 27'd0);
      send_frame(make_frame(4095, 0, 4095, 0, 4095, 0, 1, 1, 1, 1, 32'hFFFF_FFFF));
      send_frame(make_frame(0, 4095, 0, 4095, 0, 4095, 1, 0, 0, 0, 32'd0));

      for (int p = 0; p < PHASES; p++) begin
         quiesce();
         random_config();
         repeat (PHASE_ITEMS) send_frame(random_frame());
      end

      quiesce();
      if (board.errors == 0)
         $display("rc_channel_camera_action_mapper_top_test: clean");
      else
         $display("rc_channel_camera_action_mapper_top_test: errors");
      $finish;
   end
endmodule
